// ----- design/iet_pkg.sv -----
`default_nettype none
package iet_pkg;

  // fixed geometry of the taper kernel and of the pixel format
  localparam int KERNEL_SIZE  = 10;
  localparam int PIXEL_BITS   = 16;
  localparam int COEF_BITS    = 16;
  localparam int FRAC         = COEF_BITS - 1;
  localparam int ONE          = 1 << FRAC;
  localparam int HALF         = 1 << (FRAC - 1);
  localparam int MARG         = KERNEL_SIZE - 1;
  localparam int BACK         = ((KERNEL_SIZE + 1) >> 1) - 1;
  localparam int AHEAD        = KERNEL_SIZE - 1 - BACK;
  localparam int WSPAN        = 2 * KERNEL_SIZE - 1;
  localparam int KIDX_W       = $clog2(KERNEL_SIZE);
  localparam int WIX_W        = $clog2(WSPAN);
  localparam int ACC_W        = PIXEL_BITS + COEF_BITS + 8;
  localparam int CFG_W        = 11;
  localparam int MIN_DIM      = 2 * KERNEL_SIZE + 1;
  localparam int RESET_DIM    = 512;
  localparam int MAX_COLS_DEF = 1024;
  localparam int MAP_W        = 13;

  // register indexes of the configuration port
  localparam logic REG_IMAGE_ROWS = 1'b0;
  localparam logic REG_IMAGE_COLS = 1'b1;

  // normalised 1-d gaussian, sigma 1, unsigned q1.15
  localparam logic [COEF_BITS-1:0] GAUSS_H [KERNEL_SIZE] =
    '{16'd0, 16'd4, 16'd145, 16'd1769, 16'd7929,
      16'd13073, 16'd7929, 16'd1769, 16'd145, 16'd4};

  // normalised autocorrelation of the 1-d kernel, centre at MARG
  localparam logic [COEF_BITS-1:0] WEIGHT_TAB [WSPAN] =
    '{16'd0, 16'd0, 16'd0, 16'd4, 16'd62, 16'd599, 16'd3451, 16'd12053,
      16'd25514, 16'd32768, 16'd25514, 16'd12053, 16'd3451, 16'd599,
      16'd62, 16'd4, 16'd0, 16'd0, 16'd0};

  // item travelling along the row of mac cells
  typedef struct packed {
    logic                         valid;
    logic                         mark;   // closes the window, collects sums
    logic [KIDX_W-1:0]            row;
    logic [KIDX_W-1:0]            col;
    logic signed [PIXEL_BITS-1:0] re;
    logic signed [PIXEL_BITS-1:0] im;
    logic signed [ACC_W-1:0]      sum_re;
    logic signed [ACC_W-1:0]      sum_im;
  } tok_t;

  // 2-d kernel tap as the rounded outer product of the 1-d kernel
  function automatic logic [COEF_BITS-1:0] kern_coef(input logic [KIDX_W-1:0] i,
                                                     input logic [KIDX_W-1:0] j);
    logic [2*COEF_BITS-1:0] p;
    p = '0;
    if (i < KIDX_W'(KERNEL_SIZE) && j < KIDX_W'(KERNEL_SIZE)) begin
      p = GAUSS_H[i] * GAUSS_H[j] + (2*COEF_BITS)'(HALF);
    end
    return p[FRAC +: COEF_BITS];
  endfunction

  // maps a position in an extent of n onto the border weight table
  function automatic logic [WIX_W-1:0] map_pos(input logic [MAP_W-1:0] p,
                                               input logic [MAP_W-1:0] n);
    logic signed [MAP_W+1:0] t;
    logic [WIX_W-1:0]        r;
    t = $signed({2'b00, p}) - $signed({2'b00, n}) + (MAP_W+2)'(2*MARG+1);
    if (p < MAP_W'(MARG)) begin
      r = p[WIX_W-1:0];
    end else if ({1'b0, p} + (MAP_W+1)'(MARG) < {1'b0, n}) begin
      r = WIX_W'(MARG);
    end else if (t > (MAP_W+2)'(2*MARG)) begin
      r = WIX_W'(2*MARG);
    end else if (t < 0) begin
      r = '0;
    end else begin
      r = t[WIX_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/iet_ram.sv -----
`default_nettype none
module iet_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/iet_cell.sv -----
`default_nettype none
module iet_cell #(
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire iet_pkg::tok_t tin,
  output iet_pkg::tok_t      tout
);
  import iet_pkg::*;

  logic signed [ACC_W-1:0]                acc_re;
  logic signed [ACC_W-1:0]                acc_im;
  logic        [COEF_BITS-1:0]            coef;
  logic signed [PIXEL_BITS+COEF_BITS:0]   prod_re;
  logic signed [PIXEL_BITS+COEF_BITS:0]   prod_im;
  tok_t                                   tnext;

  // one kernel row per cell, the column picks the tap
  assign coef    = kern_coef(KIDX_W'(IDX), tin.col);
  assign prod_re = tin.re * $signed({1'b0, coef});
  assign prod_im = tin.im * $signed({1'b0, coef});

  // the marker picks up this row's sum on its way past
  always_comb begin
    tnext = tin;
    if (tin.valid && tin.mark) begin
      tnext.sum_re = tin.sum_re + acc_re;
      tnext.sum_im = tin.sum_im + acc_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_re <= '0;
      acc_im <= '0;
      tout   <= '0;
    end else begin
      tout <= tnext;
      if (tin.valid && tin.mark) begin
        acc_re <= '0;
        acc_im <= '0;
      end else if (tin.valid && tin.row == KIDX_W'(IDX)) begin
        acc_re <= acc_re + ACC_W'(prod_re);
        acc_im <= acc_im + ACC_W'(prod_im);
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/image_edge_taper.sv -----
`default_nettype none
// sequence: an interior pixel leaves through check, decide, center and emit after the item that
//   releases it, a border pixel through check, decide, center, taps (100 window reads), mark,
//   wait (marker through 10 cells), mul, sum and emit; emit holds while the output is stalled
// input: one item at a time; a new item is taken only back in idle, once the last one has been
//   decided and any pixel it releases emitted, tied to the single read port of the line store feeding the cell row
// reset (rst, synchronous): sizes back to 512 x 512, counters and window cleared,
//   line store contents are not cleared
module image_edge_taper #(
  parameter int MAX_COLS = iet_pkg::MAX_COLS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [iet_pkg::CFG_W-1:0]      cfg_data,
  // incoming pixels
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [2*iet_pkg::PIXEL_BITS-1:0] s_axis_tdata, // pixel_re, pixel_im
  input  wire logic                           s_axis_tuser,   // flush
  // tapered pixels
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [2*iet_pkg::PIXEL_BITS-1:0]    m_axis_tdata,   // out_re, out_im
  output logic                                m_axis_tlast    // last_of_frame
);
  import iet_pkg::*;

  localparam int CA_W    = $clog2(MAX_COLS);
  localparam int RAM_AW  = KIDX_W + CA_W;
  localparam int RAM_DEP = KERNEL_SIZE << CA_W;
  localparam int CMP_W   = ((CA_W + 1 > CFG_W) ? CA_W + 1 : CFG_W) + 1;
  localparam int TOT_W   = 2 * CFG_W;
  localparam int BLUR_W  = PIXEL_BITS + 2;
  localparam int P1_W    = PIXEL_BITS + COEF_BITS + 1;
  localparam int P2_W    = BLUR_W + COEF_BITS + 1;
  localparam int SUM_W   = P2_W + 1;
  localparam int PMAX    = (1 << (PIXEL_BITS - 1)) - 1;
  localparam int PMIN    = -(1 << (PIXEL_BITS - 1));

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DECIDE, S_CENTER, S_TAPS, S_MARK, S_WAIT,
    S_MUL, S_SUM, S_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [CFG_W-1:0] image_rows;
  logic [CFG_W-1:0] image_cols;
  logic [CFG_W-1:0] rows;
  logic [CFG_W-1:0] cols;
  logic [CMP_W-1:0] cols_raw;

  // positions
  logic [CA_W-1:0]   in_col;
  logic [KIDX_W-1:0] in_slot;
  logic [CFG_W-1:0]  out_row;
  logic [CA_W-1:0]   out_col;
  logic [KIDX_W-1:0] out_slot;
  logic [TOT_W-1:0]  pending;

  // per item registers
  logic [TOT_W-1:0]     total;
  logic [TOT_W-1:0]     q;
  logic [TOT_W-1:0]     dly;
  logic [COEF_BITS-1:0] wa;
  logic [COEF_BITS-1:0] wb;
  logic [COEF_BITS-1:0] w;
  logic                 last;
  logic signed [PIXEL_BITS-1:0] pix_re;
  logic signed [PIXEL_BITS-1:0] pix_im;
  logic signed [BLUR_W-1:0]     blur_re;
  logic signed [BLUR_W-1:0]     blur_im;
  logic signed [P1_W-1:0]       p1_re;
  logic signed [P1_W-1:0]       p1_im;
  logic signed [P2_W-1:0]       p2_re;
  logic signed [P2_W-1:0]       p2_im;
  logic signed [PIXEL_BITS-1:0] res_re;
  logic signed [PIXEL_BITS-1:0] res_im;

  // window sweep
  logic [KIDX_W-1:0] ti;
  logic [KIDX_W-1:0] tj;
  logic              iss_valid;
  logic              iss_mark;
  logic              iss_inb;
  logic [KIDX_W-1:0] iss_row;
  logic [KIDX_W-1:0] iss_col;

  // line store port
  logic                    ram_we;
  logic [RAM_AW-1:0]       ram_waddr;
  logic [RAM_AW-1:0]       ram_raddr;
  logic [RAM_AW-1:0]       tap_addr;
  logic [2*PIXEL_BITS-1:0] ram_rdata;
  logic signed [PIXEL_BITS-1:0] rd_re;
  logic signed [PIXEL_BITS-1:0] rd_im;

  // combinational helpers
  logic                  in_acc;
  logic [CA_W:0]         in_col_inc;
  logic [CA_W:0]         out_col_inc;
  logic [CFG_W:0]        out_row_inc;
  logic [CFG_W+1:0]      rr;
  logic [CMP_W:0]        cc;
  logic [KIDX_W+1:0]     slot_sum;
  logic [KIDX_W-1:0]     tap_slot;
  logic                  tap_inb;
  logic signed [TOT_W+1:0] rem;
  logic                  release_ok;
  logic [2*COEF_BITS-1:0] w_full;
  logic signed [ACC_W-1:0] bs_re;
  logic signed [ACC_W-1:0] bs_im;
  logic signed [SUM_W-1:0] v_re;
  logic signed [SUM_W-1:0] v_im;
  logic                  out_free;

  tok_t chain [KERNEL_SIZE+1];

  // effective frame size
  assign cols_raw = CMP_W'(image_cols);
  always_comb begin
    rows = (image_rows < CFG_W'(MIN_DIM)) ? CFG_W'(MIN_DIM) : image_rows;
    if (cols_raw < CMP_W'(MIN_DIM)) begin
      cols = CFG_W'(MIN_DIM);
    end else if (cols_raw > CMP_W'(MAX_COLS)) begin
      cols = CFG_W'(MAX_COLS);
    end else begin
      cols = image_cols;
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign ram_we    = in_acc && !s_axis_tuser;
  assign ram_waddr = {in_slot, in_col};
  assign ram_raddr = (state == S_DECIDE) ? {out_slot, out_col} : tap_addr;
  assign rd_re     = ram_rdata[PIXEL_BITS-1:0];
  assign rd_im     = ram_rdata[2*PIXEL_BITS-1:PIXEL_BITS];

  assign in_col_inc  = {1'b0, in_col} + 1'b1;
  assign out_col_inc = {1'b0, out_col} + 1'b1;
  assign out_row_inc = {1'b0, out_row} + 1'b1;

  // window tap position, ring slot and frame bounds
  always_comb begin
    rr       = (CFG_W+2)'(out_row) + (CFG_W+2)'(ti) - (CFG_W+2)'(BACK);
    cc       = (CMP_W+1)'(out_col) + (CMP_W+1)'(tj) - (CMP_W+1)'(BACK);
    slot_sum = (KIDX_W+2)'(out_slot) + (KIDX_W+2)'(ti) + (KIDX_W+2)'(KERNEL_SIZE - BACK);
    if (slot_sum >= (KIDX_W+2)'(KERNEL_SIZE)) begin
      slot_sum = slot_sum - (KIDX_W+2)'(KERNEL_SIZE);
    end
    if (slot_sum >= (KIDX_W+2)'(KERNEL_SIZE)) begin
      slot_sum = slot_sum - (KIDX_W+2)'(KERNEL_SIZE);
    end
    tap_slot = slot_sum[KIDX_W-1:0];
    tap_inb  = !rr[CFG_W+1] && (rr[CFG_W:0] < {1'b0, rows}) &&
               !cc[CMP_W] && (cc[CMP_W-1:0] < CMP_W'(cols));
    tap_addr = {tap_slot, cc[CA_W-1:0]};
  end

  // release test: far enough behind the input, or the frame tail has arrived
  assign rem        = $signed({2'b00, total}) - $signed({2'b00, q});
  assign release_ok = (pending != '0) &&
                      ((pending > dly) || (rem <= $signed({2'b00, pending})));
  assign w_full     = wa * wb + (2*COEF_BITS)'(HALF);

  assign bs_re = chain[KERNEL_SIZE].sum_re + ACC_W'(HALF);
  assign bs_im = chain[KERNEL_SIZE].sum_im + ACC_W'(HALF);
  assign v_re  = SUM_W'(p1_re) + SUM_W'(p2_re) + SUM_W'(HALF);
  assign v_im  = SUM_W'(p1_im) + SUM_W'(p2_im) + SUM_W'(HALF);

  // item entering the cell row, out-of-frame taps read as zero
  always_comb begin
    chain[0]        = '0;
    chain[0].valid  = iss_valid;
    chain[0].mark   = iss_mark;
    chain[0].row    = iss_row;
    chain[0].col    = iss_col;
    chain[0].re     = iss_inb ? rd_re : '0;
    chain[0].im     = iss_inb ? rd_im : '0;
  end

  function automatic logic signed [PIXEL_BITS-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] s;
    logic signed [PIXEL_BITS-1:0] r;
    s = v >>> FRAC;
    if (s > SUM_W'(PMAX)) begin
      r = PIXEL_BITS'(PMAX);
    end else if (s < SUM_W'(PMIN)) begin
      r = PIXEL_BITS'(PMIN);
    end else begin
      r = s[PIXEL_BITS-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= CFG_W'(RESET_DIM);
      image_cols <= CFG_W'(RESET_DIM);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_ROWS: image_rows <= cfg_data;
        REG_IMAGE_COLS: image_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      in_col        <= '0;
      in_slot       <= '0;
      out_row       <= '0;
      out_col       <= '0;
      out_slot      <= '0;
      pending       <= '0;
      ti            <= '0;
      tj            <= '0;
      iss_valid     <= 1'b0;
      iss_mark      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      iss_valid <= 1'b0;
      iss_mark  <= 1'b0;
      // drop the taken item unless the emit step reloads it
      if (m_axis_tready && !(state == S_EMIT && out_free)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (!s_axis_tuser) begin
              if (CMP_W'(in_col_inc) >= CMP_W'(cols)) begin
                in_col  <= '0;
                in_slot <= (in_slot == KIDX_W'(KERNEL_SIZE - 1)) ? '0 : in_slot + 1'b1;
              end else begin
                in_col <= in_col_inc[CA_W-1:0];
              end
              pending <= pending + 1'b1;
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          total <= rows * cols;
          q     <= out_row * cols + TOT_W'(out_col);
          dly   <= TOT_W'(AHEAD) * TOT_W'(cols) + TOT_W'(AHEAD);
          wa    <= WEIGHT_TAB[map_pos(MAP_W'(out_row), MAP_W'(rows))];
          wb    <= WEIGHT_TAB[map_pos(MAP_W'(out_col), MAP_W'(cols))];
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          last  <= (q + 1'b1 == total);
          w     <= w_full[FRAC +: COEF_BITS];
          state <= release_ok ? S_CENTER : S_IDLE;
        end
        S_CENTER: begin
          pix_re <= rd_re;
          pix_im <= rd_im;
          ti     <= '0;
          tj     <= '0;
          if (w == COEF_BITS'(ONE)) begin
            // interior pixel passes untouched
            res_re <= rd_re;
            res_im <= rd_im;
            state  <= S_EMIT;
          end else begin
            state <= S_TAPS;
          end
        end
        S_TAPS: begin
          iss_valid <= 1'b1;
          iss_row   <= ti;
          iss_col   <= tj;
          iss_inb   <= tap_inb;
          if (tj == KIDX_W'(KERNEL_SIZE - 1)) begin
            tj <= '0;
            if (ti == KIDX_W'(KERNEL_SIZE - 1)) begin
              state <= S_MARK;
            end else begin
              ti <= ti + 1'b1;
            end
          end else begin
            tj <= tj + 1'b1;
          end
        end
        S_MARK: begin
          // marker follows the last tap and gathers the row sums
          iss_valid <= 1'b1;
          iss_mark  <= 1'b1;
          iss_inb   <= 1'b0;
          state     <= S_WAIT;
        end
        S_WAIT: begin
          if (chain[KERNEL_SIZE].valid && chain[KERNEL_SIZE].mark) begin
            blur_re <= BLUR_W'(bs_re >>> FRAC);
            blur_im <= BLUR_W'(bs_im >>> FRAC);
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          p1_re <= $signed({1'b0, w}) * pix_re;
          p1_im <= $signed({1'b0, w}) * pix_im;
          p2_re <= $signed({1'b0, COEF_BITS'(ONE) - w}) * blur_re;
          p2_im <= $signed({1'b0, COEF_BITS'(ONE) - w}) * blur_im;
          state <= S_SUM;
        end
        S_SUM: begin
          res_re <= sat(v_re);
          res_im <= sat(v_im);
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {res_im, res_re};
            m_axis_tlast  <= last;
            pending       <= pending - 1'b1;
            if (CMP_W'(out_col_inc) >= CMP_W'(cols)) begin
              out_col  <= '0;
              out_slot <= (out_slot == KIDX_W'(KERNEL_SIZE - 1)) ? '0 : out_slot + 1'b1;
              out_row  <= (out_row_inc >= {1'b0, rows}) ? '0 : out_row_inc[CFG_W-1:0];
            end else begin
              out_col <= out_col_inc[CA_W-1:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  iet_ram #(
    .WIDTH(2 * PIXEL_BITS),
    .DEPTH(RAM_DEP)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(s_axis_tdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // one mac cell per kernel row
  for (genvar g = 0; g < KERNEL_SIZE; g++) begin : g_cell
    iet_cell #(.IDX(g)) u_cell (
      .clk (clk),
      .rst (rst),
      .tin (chain[g]),
      .tout(chain[g+1])
    );
  end

  // the window marker only leaves the cell row while the sequencer waits for it
  a_mark_in_wait: assert property (@(posedge clk) disable iff (rst)
    (chain[KERNEL_SIZE].valid && chain[KERNEL_SIZE].mark) |-> (state == S_WAIT))
    else $error("window marker outside wait");

  // a result only appears from the emit step
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_EMIT))
    else $error("result loaded outside emit");

  // ring slots stay inside the kernel height
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (in_slot < KIDX_W'(KERNEL_SIZE)) && (out_slot < KIDX_W'(KERNEL_SIZE)))
    else $error("ring slot out of range");

  // a sweep tap never points beyond the kernel
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAPS) |-> (ti < KIDX_W'(KERNEL_SIZE) && tj < KIDX_W'(KERNEL_SIZE)))
    else $error("tap index out of range");

endmodule
`default_nettype wire
